[design/wcf_pkg.sv]
// Shared types, constants and kernel tables for the window convolution filter.
package wcf_pkg;

    // Field and port widths.
    localparam int PIX_W       = 8;
    localparam int OUT_W       = 18;
    localparam int TDATA_OUT_W = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int BPP_W       = 3;
    localparam int KSEL_W      = 2;
    localparam int CH_W        = 2;
    localparam int MAX_CH      = 4;
    localparam int KDIM_W      = 3;

    // Arithmetic widths in the multiply and add tree.
    localparam int WEIGHT_W = 7;
    localparam int PROD_W   = 16;
    localparam int SUM_W    = 20;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SELECT   = 2'd3;

    // Kernel selector codes.
    localparam logic [KSEL_W-1:0] KSEL_GAUSS   = 2'd0;
    localparam logic [KSEL_W-1:0] KSEL_SOBEL_A = 2'd1;
    localparam logic [KSEL_W-1:0] KSEL_SOBEL_B = 2'd2;

    // Kernel sizes.
    localparam int GAUSS_K = 5;
    localparam int SOBEL_K = 3;

    // Reset values of the registers.
    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd128;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 11'd128;
    localparam logic [BPP_W-1:0]      BPP_RESET    = 3'd4;

    // Weight tables, indexed [horizontal offset * size + vertical offset].
    localparam logic signed [WEIGHT_W-1:0] GAUSS_TAB [GAUSS_K*GAUSS_K] = '{
        7'sd1,  7'sd4,  7'sd7,  7'sd4,  7'sd1,
        7'sd4,  7'sd16, 7'sd26, 7'sd16, 7'sd4,
        7'sd7,  7'sd26, 7'sd41, 7'sd26, 7'sd7,
        7'sd4,  7'sd16, 7'sd26, 7'sd16, 7'sd4,
        7'sd1,  7'sd4,  7'sd7,  7'sd4,  7'sd1
    };
    localparam logic signed [WEIGHT_W-1:0] SOBEL_A_TAB [SOBEL_K*SOBEL_K] = '{
        -7'sd1, 7'sd0, 7'sd1, -7'sd2, 7'sd0, 7'sd2, -7'sd1, 7'sd0, 7'sd1
    };
    localparam logic signed [WEIGHT_W-1:0] SOBEL_B_TAB [SOBEL_K*SOBEL_K] = '{
        -7'sd1, -7'sd2, -7'sd1, 7'sd0, 7'sd0, 7'sd0, 7'sd1, 7'sd2, 7'sd1
    };

    // Control fields that travel with each byte from front to back.
    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic [KSEL_W-1:0] ksel;
        logic              emit;
        logic              last;
    } item_ctrl_t;

    // Weight at column i, row j of a 5x5 grid; the 3x3 tables sit in the
    // lower right corner so that all kernels share the newest columns and rows.
    function automatic logic signed [WEIGHT_W-1:0] kernel_weight(
        input logic [KSEL_W-1:0] ksel,
        input int                i,
        input int                j
    );
        logic signed [WEIGHT_W-1:0] w;
        int                         off;
        off = GAUSS_K - SOBEL_K;
        w   = '0;
        if (ksel == KSEL_SOBEL_A) begin
            if (i >= off && j >= off) begin
                w = SOBEL_A_TAB[(i - off) * SOBEL_K + (j - off)];
            end
        end else if (ksel == KSEL_SOBEL_B) begin
            if (i >= off && j >= off) begin
                w = SOBEL_B_TAB[(i - off) * SOBEL_K + (j - off)];
            end
        end else begin
            w = GAUSS_TAB[i * GAUSS_K + j];
        end
        return w;
    endfunction

endpackage

[design/wcf_fifo.sv]
// Small register-based stream queue with valid/ready on both sides.
module wcf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg < CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[design/wcf_front.sv]
// Front end: configuration registers, raster position counters and item classification.
module wcf_front import wcf_pkg::*; #(
    parameter int MAX_LINE_BYTES = 4096,
    parameter int MAX_LINES      = 1024,
    parameter int KERNEL_MAX     = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [PIX_W-1:0]              s_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    output logic                          q_valid,
    input  logic                          q_ready,
    output logic [PIX_W-1:0]              q_byte,
    output logic [$clog2(MAX_LINE_BYTES)-1:0] q_col,
    output item_ctrl_t                    q_ctrl
);

    localparam int COL_W  = $clog2(MAX_LINE_BYTES);
    localparam int ROW_W  = $clog2(MAX_LINES);
    localparam int WCAP_W = $clog2(MAX_LINE_BYTES + 1);
    localparam int LW     = (WCAP_W > CFG_DATA_W) ? WCAP_W : CFG_DATA_W;
    localparam int HCAP_W = $clog2(MAX_LINES + 1);
    localparam int HW     = (HCAP_W > CFG_DATA_W) ? HCAP_W : CFG_DATA_W;

    localparam logic [LW-1:0] WCAP_1 = LW'(MAX_LINE_BYTES);
    localparam logic [LW-1:0] WCAP_2 = LW'(MAX_LINE_BYTES / 2);
    localparam logic [LW-1:0] WCAP_3 = LW'(MAX_LINE_BYTES / 3);
    localparam logic [LW-1:0] WCAP_4 = LW'(MAX_LINE_BYTES / 4);
    localparam logic [HW-1:0] HCAP   = HW'(MAX_LINES);
    localparam logic          GAUSS_FITS = (GAUSS_K <= KERNEL_MAX);

    logic [CFG_DATA_W-1:0] width_reg, width_next;
    logic [CFG_DATA_W-1:0] height_reg, height_next;
    logic [BPP_W-1:0]      bpp_reg, bpp_next;
    logic [KSEL_W-1:0]     ksel_reg, ksel_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [COL_W-1:0]      px_reg, px_next;
    logic [CH_W-1:0]       ch_reg, ch_next;
    logic [ROW_W-1:0]      row_reg, row_next;

    logic [BPP_W-1:0]  b_eff;
    logic [CH_W-1:0]   b_last;
    logic [LW-1:0]     w_cap, w_ext, w_eff;
    logic [COL_W-1:0]  w_last;
    logic [HW-1:0]     h_ext, h_eff;
    logic [ROW_W-1:0]  h_last;
    logic [KSEL_W-1:0] ksel_item;
    logic [KDIM_W-1:0] k_last;
    logic              k_fits;
    logic              end_line, last_flag, emit_ok;
    logic              in_fire, cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_tready  = q_ready;
    assign in_fire   = s_tvalid && s_tready;

    // Effective geometry after clamping the registers.
    always_comb begin
        if (bpp_reg == '0) begin
            b_eff = BPP_W'(1);
        end else if (bpp_reg > BPP_W'(MAX_CH)) begin
            b_eff = BPP_W'(MAX_CH);
        end else begin
            b_eff = bpp_reg;
        end
        b_last = CH_W'(b_eff - BPP_W'(1));

        unique case (b_eff)
            BPP_W'(1): w_cap = WCAP_1;
            BPP_W'(2): w_cap = WCAP_2;
            BPP_W'(3): w_cap = WCAP_3;
            default:   w_cap = WCAP_4;
        endcase

        w_ext = LW'(width_reg);
        if (w_ext == '0) begin
            w_eff = LW'(1);
        end else if (w_ext > w_cap) begin
            w_eff = w_cap;
        end else begin
            w_eff = w_ext;
        end
        w_last = COL_W'(w_eff - LW'(1));

        h_ext = HW'(height_reg);
        if (h_ext == '0) begin
            h_eff = HW'(1);
        end else if (h_ext > HCAP) begin
            h_eff = HCAP;
        end else begin
            h_eff = h_ext;
        end
        h_last = ROW_W'(h_eff - HW'(1));
    end

    // Kernel choice; the unused selector code falls back to the Gaussian.
    always_comb begin
        if (ksel_reg == KSEL_SOBEL_A || ksel_reg == KSEL_SOBEL_B) begin
            ksel_item = ksel_reg;
            k_last    = KDIM_W'(SOBEL_K - 1);
            k_fits    = 1'b1;
        end else begin
            ksel_item = KSEL_GAUSS;
            k_last    = KDIM_W'(GAUSS_K - 1);
            k_fits    = GAUSS_FITS;
        end
    end

    // Classification of the current byte.
    assign end_line  = (px_reg == w_last) && (ch_reg == b_last);
    assign last_flag = end_line && (row_reg == h_last);
    assign emit_ok   = k_fits && (px_reg >= COL_W'(k_last)) && (row_reg >= ROW_W'(k_last));

    assign q_valid = s_tvalid;
    assign q_byte  = s_tdata;
    assign q_col   = col_reg;
    assign q_ctrl  = '{ch: ch_reg, ksel: ksel_item, emit: emit_ok, last: last_flag};

    // Register writes restart the frame; accepted bytes advance the raster position.
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        bpp_next    = bpp_reg;
        ksel_next   = ksel_reg;
        col_next    = col_reg;
        px_next     = px_reg;
        ch_next     = ch_reg;
        row_next    = row_reg;
        if (cfg_fire) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:     width_next  = cfg_data;
                REG_IMAGE_HEIGHT:    height_next = cfg_data;
                REG_BYTES_PER_PIXEL: bpp_next    = cfg_data[BPP_W-1:0];
                REG_KERNEL_SELECT:   ksel_next   = cfg_data[KSEL_W-1:0];
            endcase
            col_next = '0;
            px_next  = '0;
            ch_next  = '0;
            row_next = '0;
        end else if (in_fire) begin
            if (end_line) begin
                col_next = '0;
                px_next  = '0;
                ch_next  = '0;
                row_next = (row_reg == h_last) ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
                if (ch_reg == b_last) begin
                    ch_next = '0;
                    px_next = px_reg + COL_W'(1);
                end else begin
                    ch_next = ch_reg + CH_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            bpp_reg    <= BPP_RESET;
            ksel_reg   <= KSEL_GAUSS;
            col_reg    <= '0;
            px_reg     <= '0;
            ch_reg     <= '0;
            row_reg    <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            bpp_reg    <= bpp_next;
            ksel_reg   <= ksel_next;
            col_reg    <= col_next;
            px_reg     <= px_next;
            ch_reg     <= ch_next;
            row_reg    <= row_next;
        end
    end

endmodule

[design/wcf_window.sv]
// Back end, first half: vertical line memory and per-channel window registers.
module wcf_window import wcf_pkg::*; #(
    parameter int MAX_LINE_BYTES = 4096,
    parameter int KERNEL_MAX     = 5
) (
    input  logic                                               aclk,
    input  logic                                               aresetn,
    input  logic                                               in_valid,
    input  logic [PIX_W-1:0]                                   in_byte,
    input  logic [$clog2(MAX_LINE_BYTES)-1:0]                  in_col,
    input  item_ctrl_t                                         in_ctrl,
    output logic                                               out_valid,
    output item_ctrl_t                                         out_ctrl,
    output logic [KERNEL_MAX-1:0][KERNEL_MAX-1:0][PIX_W-1:0]   out_win
);

    localparam int COL_W = $clog2(MAX_LINE_BYTES);
    localparam int LANES = KERNEL_MAX - 1;

    typedef logic [LANES-1:0][PIX_W-1:0]                     lanes_t;
    typedef logic [KERNEL_MAX-1:0][PIX_W-1:0]                column_t;
    typedef logic [KERNEL_MAX-1:0][KERNEL_MAX-1:0][PIX_W-1:0] window_t;

    // Each entry holds the bytes of one column for the previous lines, newest in lane 0.
    lanes_t     line_mem [MAX_LINE_BYTES];
    lanes_t     rd_data_reg;
    lanes_t     byp_data_reg;
    logic       byp_reg;
    lanes_t     lanes;
    lanes_t     wr_data;
    column_t    new_col;
    window_t    win_reg [MAX_CH];
    window_t    cur_win, shifted;
    window_t    win_out_reg;

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_byte_reg;
    logic [COL_W-1:0] s1_col_reg;
    item_ctrl_t       s1_ctrl_reg;
    logic             s2_valid_reg;
    item_ctrl_t       s2_ctrl_reg;

    // A read that hits the column being written this cycle takes the new data.
    assign lanes = byp_reg ? byp_data_reg : rd_data_reg;

    // Column for the current byte: oldest line in row 0, current line last.
    always_comb begin
        new_col[KERNEL_MAX-1] = s1_byte_reg;
        for (int m = 0; m < LANES; m++) begin
            new_col[KERNEL_MAX-2-m] = lanes[m];
        end
        wr_data[0] = s1_byte_reg;
        for (int m = 1; m < LANES; m++) begin
            wr_data[m] = lanes[m-1];
        end
    end

    // Slide the window of this byte's channel by one column.
    always_comb begin
        cur_win = win_reg[s1_ctrl_reg.ch];
        for (int i = 0; i < KERNEL_MAX - 1; i++) begin
            shifted[i] = cur_win[i+1];
        end
        shifted[KERNEL_MAX-1] = new_col;
    end

    // Line memory: read at the queue head, write back the shifted column.
    always_ff @(posedge aclk) begin
        if (in_valid) begin
            rd_data_reg <= line_mem[in_col];
        end
        if (s1_valid_reg) begin
            line_mem[s1_col_reg] <= wr_data;
        end
        byp_data_reg <= wr_data;
    end

    // Window registers and the snapshot handed to the multiply stage.
    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            win_reg[s1_ctrl_reg.ch] <= shifted;
            win_out_reg             <= shifted;
        end
        s1_byte_reg <= in_byte;
        s1_col_reg  <= in_col;
        s1_ctrl_reg <= in_ctrl;
        s2_ctrl_reg <= s1_ctrl_reg;
    end

    // Stage valid bits and the bypass flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            byp_reg      <= in_valid && s1_valid_reg && (in_col == s1_col_reg);
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_ctrl  = s2_ctrl_reg;
    assign out_win   = win_out_reg;

endmodule

[design/wcf_mac.sv]
// Back end, second half: weight products and a registered adder tree.
module wcf_mac import wcf_pkg::*; #(
    parameter int KERNEL_MAX = 5
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic                                             in_valid,
    input  item_ctrl_t                                       in_ctrl,
    input  logic [KERNEL_MAX-1:0][KERNEL_MAX-1:0][PIX_W-1:0] in_win,
    output logic                                             out_valid,
    output logic signed [OUT_W-1:0]                          out_value,
    output logic                                             out_last
);

    localparam int OFF = GAUSS_K - KERNEL_MAX;

    logic signed [PROD_W-1:0] prod_next [KERNEL_MAX][KERNEL_MAX];
    logic signed [PROD_W-1:0] prod_reg  [KERNEL_MAX][KERNEL_MAX];
    logic signed [SUM_W-1:0]  part_next [KERNEL_MAX];
    logic signed [SUM_W-1:0]  part_reg  [KERNEL_MAX];
    logic signed [SUM_W-1:0]  total;
    logic signed [OUT_W-1:0]  value_reg;
    logic                     s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic                     s3_last_reg, s4_last_reg, s5_last_reg;

    // Products; a zero weight gives zero whatever the byte holds.
    always_comb begin
        logic signed [WEIGHT_W-1:0] wt;
        wt = '0;
        for (int i = 0; i < KERNEL_MAX; i++) begin
            for (int j = 0; j < KERNEL_MAX; j++) begin
                wt = kernel_weight(in_ctrl.ksel, i + OFF, j + OFF);
                if (wt == '0) begin
                    prod_next[i][j] = '0;
                end else begin
                    prod_next[i][j] = PROD_W'(wt) * PROD_W'($signed({1'b0, in_win[i][j]}));
                end
            end
        end
    end

    // Column sums over the window rows.
    always_comb begin
        for (int i = 0; i < KERNEL_MAX; i++) begin
            part_next[i] = '0;
            for (int j = 0; j < KERNEL_MAX; j++) begin
                part_next[i] = part_next[i] + SUM_W'(prod_reg[i][j]);
            end
        end
    end

    // Final sum across the columns.
    always_comb begin
        total = '0;
        for (int i = 0; i < KERNEL_MAX; i++) begin
            total = total + part_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg    <= prod_next;
        part_reg    <= part_next;
        value_reg   <= $signed(total[OUT_W-1:0]);
        s3_last_reg <= in_ctrl.last;
        s4_last_reg <= s3_last_reg;
        s5_last_reg <= s4_last_reg;
    end

    // Only items that produce a result travel as valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else begin
            s3_valid_reg <= in_valid && in_ctrl.emit;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_value = value_reg;
    assign out_last  = s5_last_reg;

endmodule

[design/window_convolution_filter_top.sv]
// Top level of the window convolution filter: front end, queue, back end and result buffer.
//
//  channel  | direction | word carries
//  ---------+-----------+--------------------------------------------------------
//  s_       | in        | tdata[7:0] pixel_byte, one channel byte in raster order
//  m_       | out       | tdata[17:0] filtered_value (signed), tlast last_of_frame
//  cfg_     | in        | index 0 width, 1 height, 2 bytes per pixel, 3 kernel
//
// Sustained rate is one byte per cycle while the result buffer has room; the line memory
// does one read and one write per byte and every stage after it is fully pipelined.
// A result word is offered on m_tvalid after the byte at its window's lower right corner is
// accepted and passes through the queue, stages s1 to s5 and the result buffer.
// Reset loads the register defaults and empties all queues; the line memory needs no
// clearing, since a result only uses lines that its frame has already written.
// The result buffer holds 16 words; the back end takes a result-producing byte from the
// input queue only with a slot reserved there, so an output stall backs up into s_tready.
module window_convolution_filter_top import wcf_pkg::*; #(
    parameter int MAX_LINE_BYTES = 4096,
    parameter int MAX_LINES      = 1024,
    parameter int KERNEL_MAX     = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [PIX_W-1:0]       s_tdata,    // [7:0] pixel_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,    // [17:0] filtered_value, [23:18] zero
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int COL_W     = $clog2(MAX_LINE_BYTES);
    localparam int CTRL_W    = $bits(item_ctrl_t);
    localparam int QW        = CTRL_W + COL_W + PIX_W;
    localparam int Q_DEPTH   = 4;
    localparam int OUT_DEPTH = 16;
    localparam int RES_W     = $clog2(OUT_DEPTH + 1);

    logic                   f_valid, f_ready;
    logic [PIX_W-1:0]       f_byte;
    logic [COL_W-1:0]       f_col;
    item_ctrl_t             f_ctrl;

    logic                   q_valid, q_ready;
    logic [QW-1:0]          q_data;
    logic [PIX_W-1:0]       q_byte;
    logic [COL_W-1:0]       q_col;
    item_ctrl_t             q_ctrl;
    logic                   pop;

    logic                   w_valid;
    item_ctrl_t             w_ctrl;
    logic [KERNEL_MAX-1:0][KERNEL_MAX-1:0][PIX_W-1:0] w_win;

    logic                   mac_valid;
    logic signed [OUT_W-1:0] mac_value;
    logic                   mac_last;
    logic [OUT_W:0]         o_data;

    logic [RES_W-1:0]       reserved_reg, reserved_next;

    // Front end.
    wcf_front #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .MAX_LINES      (MAX_LINES),
        .KERNEL_MAX     (KERNEL_MAX)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (f_valid),
        .q_ready   (f_ready),
        .q_byte    (f_byte),
        .q_col     (f_col),
        .q_ctrl    (f_ctrl)
    );

    // Queue between front and back.
    wcf_fifo #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_ctrl, f_col, f_byte}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    assign q_byte = q_data[PIX_W-1:0];
    assign q_col  = q_data[PIX_W +: COL_W];
    assign q_ctrl = item_ctrl_t'(q_data[QW-1 -: CTRL_W]);

    // A result-producing word leaves the queue only with a buffer slot reserved.
    assign q_ready = !q_ctrl.emit || (reserved_reg < RES_W'(OUT_DEPTH));
    assign pop     = q_valid && q_ready;

    always_comb begin
        reserved_next = reserved_reg + RES_W'(pop && q_ctrl.emit)
                        - RES_W'(m_tvalid && m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reserved_reg <= '0;
        end else begin
            reserved_reg <= reserved_next;
        end
    end

    // Back end: line memory and windows, then the multiply and add tree.
    wcf_window #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .KERNEL_MAX     (KERNEL_MAX)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pop),
        .in_byte   (q_byte),
        .in_col    (q_col),
        .in_ctrl   (q_ctrl),
        .out_valid (w_valid),
        .out_ctrl  (w_ctrl),
        .out_win   (w_win)
    );

    wcf_mac #(
        .KERNEL_MAX (KERNEL_MAX)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (w_valid),
        .in_ctrl   (w_ctrl),
        .in_win    (w_win),
        .out_valid (mac_valid),
        .out_value (mac_value),
        .out_last  (mac_last)
    );

    // Result buffer; reservation guarantees it never overflows.
    wcf_fifo #(
        .WIDTH (OUT_W + 1),
        .DEPTH (OUT_DEPTH)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mac_valid),
        .in_ready  (),
        .in_data   ({mac_last, mac_value}),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (o_data)
    );

    assign m_tdata = {{(TDATA_OUT_W - OUT_W){1'b0}}, o_data[OUT_W-1:0]};
    assign m_tlast = o_data[OUT_W];

endmodule

[design/wcf_checker.sv]
// Port-level checks on the filter's result channel, bound to the top level.
module wcf_checker import wcf_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [TDATA_OUT_W-1:0] m_tdata,
    input logic                   m_tlast
);

    // Reset leaves no result word pending.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    // The padding above the filtered value is always zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[TDATA_OUT_W-1:OUT_W] == '0))
        else $error("nonzero padding in result word");

    // Every kernel bounds the sum: Sobel cannot go below -1020, Gaussian not above 69615.
    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[OUT_W-1:0]) >= -1020 &&
                      $signed(m_tdata[OUT_W-1:0]) <= 69615))
        else $error("filtered value outside the kernel range");

    // A stalled result word stays valid.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its contents.
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

endmodule

bind window_convolution_filter_top wcf_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
